// ===== rtl/core/brie_pkg.sv =====
`timescale 1ns / 1ps
package brie_pkg;

  localparam int          STACK_ENTRIES_DEF = 16;
  localparam logic [11:0] START_ADDRESS_DEF = 12'h200;

  localparam logic [15:0] OP_RET   = 16'h00EE;
  localparam logic [3:0]  FLAG_REG = 4'hF;
  localparam logic [3:0]  BASE_REG = 4'h0;
  localparam logic [3:0]  N_ZERO   = 4'h0;

  typedef enum logic [3:0] {
    CLS_SYS   = 4'h0,
    CLS_JP    = 4'h1,
    CLS_CALL  = 4'h2,
    CLS_SE    = 4'h3,
    CLS_SNE   = 4'h4,
    CLS_SER   = 4'h5,
    CLS_LD    = 4'h6,
    CLS_ADDI  = 4'h7,
    CLS_ALU   = 4'h8,
    CLS_SNER  = 4'h9,
    CLS_LDI   = 4'hA,
    CLS_JPO   = 4'hB,
    CLS_RND   = 4'hC,
    CLS_DRW   = 4'hD,
    CLS_KEY   = 4'hE,
    CLS_MISC  = 4'hF
  } cls_t;

  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_op_t;

  typedef logic [15:0][7:0] gregs_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    logic [11:0] tos;
  } stk_stat_t;

  typedef struct packed {
    logic [11:0] pc_nxt;
    logic [11:0] index_nxt;
    logic        gx_we;
    logic [7:0]  gx_val;
    logic        gf_we;
    logic [7:0]  gf_val;
    logic        push;
    logic        pop;
    logic [11:0] push_val;
    logic [7:0]  dest;
    logic [7:0]  flag;
    logic        unsup;
    logic        fault;
  } exec_res_t;

endpackage

// ===== rtl/core/brie_if.sv =====
`timescale 1ns / 1ps
interface brie_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] opcode;
  logic [7:0]  random_byte;

  modport source (output valid, output opcode, output random_byte, input ready);
  modport sink   (input valid, input opcode, input random_byte, output ready);
endinterface

interface brie_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic [7:0]  dest_value;
  logic [7:0]  flag_value;
  logic [11:0] index_value;
  logic        unsupported;
  logic        stack_fault;

  modport source (output valid, output next_pc, output dest_value, output flag_value,
                  output index_value, output unsupported, output stack_fault,
                  input ready);
  modport sink   (input valid, input next_pc, input dest_value, input flag_value,
                  input index_value, input unsupported, input stack_fault,
                  output ready);
endinterface

// ===== rtl/core/brie_exec.sv =====
`timescale 1ns / 1ps
module brie_exec
  import brie_pkg::*;
(
  input  logic [15:0] opcode,
  input  logic [7:0]  random_byte,
  input  logic        quirk,
  input  gregs_t      gregs,
  input  logic [11:0] pc,
  input  logic [11:0] index_reg,
  input  stk_stat_t   stk,
  output exec_res_t   res
);

  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [7:0]  vx, vy, vf, shsrc, boff;
  logic [11:0] pc_inc, pc_skip;
  logic [8:0]  sum9;
  exec_res_t   r;

  always_comb begin
    x       = opcode[11:8];
    y       = opcode[7:4];
    n       = opcode[3:0];
    nn      = opcode[7:0];
    nnn     = opcode[11:0];
    vx      = gregs[x];
    vy      = gregs[y];
    vf      = gregs[FLAG_REG];
    pc_inc  = pc + 12'd2;
    pc_skip = pc + 12'd4;
    sum9    = {1'b0, vx} + {1'b0, vy};
    shsrc   = quirk ? vy : vx;
    boff    = quirk ? gregs[BASE_REG] : vx;

    r           = '0;
    r.pc_nxt    = pc_inc;
    r.index_nxt = index_reg;
    r.push_val  = pc_inc;

    case (cls_t'(opcode[15:12]))
      CLS_SYS: begin
        if (opcode == OP_RET) begin
          if (stk.empty) begin
            r.fault  = 1'b1;
            r.pc_nxt = pc;
          end else begin
            r.pop    = 1'b1;
            r.pc_nxt = stk.tos;
          end
        end else begin
          r.unsup = 1'b1;
        end
      end
      CLS_JP: r.pc_nxt = nnn;
      CLS_CALL: begin
        if (stk.full) begin
          r.fault  = 1'b1;
          r.pc_nxt = pc;
        end else begin
          r.push   = 1'b1;
          r.pc_nxt = nnn;
        end
      end
      CLS_SE:  if (vx == nn) r.pc_nxt = pc_skip;
      CLS_SNE: if (vx != nn) r.pc_nxt = pc_skip;
      CLS_SER: begin
        if (n != N_ZERO) r.unsup = 1'b1;
        else if (vx == vy) r.pc_nxt = pc_skip;
      end
      CLS_LD: begin
        r.gx_we  = 1'b1;
        r.gx_val = nn;
      end
      CLS_ADDI: begin
        r.gx_we  = 1'b1;
        r.gx_val = vx + nn;
      end
      CLS_ALU: begin
        case (alu_op_t'(n))
          ALU_MOV: begin
            r.gx_we  = 1'b1;
            r.gx_val = vy;
          end
          ALU_OR, ALU_AND, ALU_XOR: begin
            r.gx_we  = 1'b1;
            r.gx_val = (n == ALU_OR)  ? (vx | vy) :
                       (n == ALU_AND) ? (vx & vy) : (vx ^ vy);
            r.gf_we  = quirk;
            r.gf_val = 8'h00;
          end
          ALU_ADD: begin
            r.gx_we  = 1'b1;
            r.gx_val = sum9[7:0];
            r.gf_we  = 1'b1;
            r.gf_val = {7'd0, sum9[8]};
          end
          ALU_SUB: begin
            r.gx_we  = 1'b1;
            r.gx_val = vx - vy;
            r.gf_we  = 1'b1;
            r.gf_val = {7'd0, vx >= vy};
          end
          ALU_SUBN: begin
            r.gx_we  = 1'b1;
            r.gx_val = vy - vx;
            r.gf_we  = 1'b1;
            r.gf_val = {7'd0, vy >= vx};
          end
          ALU_SHR: begin
            r.gx_we  = 1'b1;
            r.gx_val = {1'b0, shsrc[7:1]};
            r.gf_we  = 1'b1;
            r.gf_val = {7'd0, shsrc[0]};
          end
          ALU_SHL: begin
            r.gx_we  = 1'b1;
            r.gx_val = {shsrc[6:0], 1'b0};
            r.gf_we  = 1'b1;
            r.gf_val = {7'd0, shsrc[7]};
          end
          default: r.unsup = 1'b1;
        endcase
      end
      CLS_SNER: begin
        if (n != N_ZERO) r.unsup = 1'b1;
        else if (vx != vy) r.pc_nxt = pc_skip;
      end
      CLS_LDI: r.index_nxt = nnn;
      CLS_JPO: r.pc_nxt = nnn + {4'h0, boff};
      CLS_RND: begin
        r.gx_we  = 1'b1;
        r.gx_val = random_byte & nn;
      end
      default: r.unsup = 1'b1;
    endcase

    // flag write lands after the destination write
    if (r.gf_we && x == FLAG_REG) r.dest = r.gf_val;
    else if (r.gx_we)             r.dest = r.gx_val;
    else                          r.dest = vx;

    if (r.gf_we)                         r.flag = r.gf_val;
    else if (r.gx_we && x == FLAG_REG)   r.flag = r.gx_val;
    else                                 r.flag = vf;

    res = r;
  end

endmodule

// ===== rtl/core/byte_register_instruction_executor.sv =====
`timescale 1ns / 1ps
// Result: registered, available the cycle after the input transaction is accepted.
// Throughput: one instruction per cycle unless the output stalls; register file,
//   PC and stack update at the accepting edge; next instruction sees them at once.
// Reset (rst_n low, synchronous): registers V0..VF, index and stack depth clear,
//   program counter loads START_ADDRESS, quirk mode clears, no result pending.
//   Return stack entries are not cleared.
module byte_register_instruction_executor
  import brie_pkg::*;
#(
  parameter int          STACK_ENTRIES = STACK_ENTRIES_DEF,
  parameter logic [11:0] START_ADDRESS = START_ADDRESS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  brie_in_if.sink     in_chan,
  brie_out_if.source  out_chan
);

  localparam int ADDR_W  = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);

  // Architectural state
  gregs_t              gregs_r, gregs_nxt;
  logic [11:0]         pc_r;
  logic [11:0]         index_r;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic                quirk_r;

  // Return stack: top entry in a register, the rest in memory, and the entry
  // just below the top kept prefetched so a return need not wait for a memory read.
  logic [11:0]         tos_r;
  logic [11:0]         below_r;
  logic [11:0]         stack_mem [STACK_ENTRIES];
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [DEPTH_W-1:0]  depth_m1, depth_nxt_m2;

  // Result register
  logic                out_valid_r;
  logic [11:0]         out_pc_r;
  logic [7:0]          out_dest_r;
  logic [7:0]          out_flag_r;
  logic [11:0]         out_index_r;
  logic                out_unsup_r;
  logic                out_fault_r;

  logic                accept;
  stk_stat_t           stk;
  exec_res_t           res;

  // Take a new transaction whenever the result register is free or draining.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign stk.empty = (depth_r == '0);
  assign stk.full  = (depth_r == DEPTH_W'(STACK_ENTRIES));
  assign stk.tos   = tos_r;

  brie_exec u_exec (
    .opcode      (in_chan.opcode),
    .random_byte (in_chan.random_byte),
    .quirk       (quirk_r),
    .gregs       (gregs_r),
    .pc          (pc_r),
    .index_reg   (index_r),
    .stk         (stk),
    .res         (res)
  );

  // Apply the destination write first, then the flag write, so the flag wins
  // when X names register fifteen.
  always_comb begin
    gregs_nxt = gregs_r;
    if (res.gx_we) gregs_nxt[in_chan.opcode[11:8]] = res.gx_val;
    if (res.gf_we) gregs_nxt[FLAG_REG]             = res.gf_val;
  end

  always_comb begin
    depth_nxt = depth_r;
    if (accept && res.push)     depth_nxt = depth_r + DEPTH_W'(1);
    else if (accept && res.pop) depth_nxt = depth_r - DEPTH_W'(1);
  end

  // Address arithmetic wraps below zero; such reads only occur when the stack
  // holds fewer than two entries and the prefetched value goes unused.
  assign depth_m1     = depth_r - DEPTH_W'(1);
  assign depth_nxt_m2 = depth_nxt - DEPTH_W'(2);
  assign wr_addr      = depth_m1[ADDR_W-1:0];
  assign rd_addr      = depth_nxt_m2[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gregs_r <= '0;
      pc_r    <= START_ADDRESS;
      index_r <= '0;
      depth_r <= '0;
      quirk_r <= 1'b0;
    end else begin
      if (cfg_we) quirk_r <= cfg_wdata;
      if (accept) begin
        gregs_r <= gregs_nxt;
        pc_r    <= res.pc_nxt;
        index_r <= res.index_nxt;
        depth_r <= depth_nxt;
      end
    end
  end

  // Stack storage: push spills the old top into memory, pop pulls the
  // prefetched entry up. Bypass the prefetch on push since that entry is
  // being written this cycle.
  always_ff @(posedge clk) begin
    if (accept && res.push) begin
      stack_mem[wr_addr] <= tos_r;
      tos_r              <= res.push_val;
      below_r            <= tos_r;
    end else begin
      if (accept && res.pop) tos_r <= below_r;
      below_r <= stack_mem[rd_addr];
    end
  end

  // Result register: hold while stalled, load on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pc_r    <= res.pc_nxt;
      out_dest_r  <= res.dest;
      out_flag_r  <= res.flag;
      out_index_r <= res.index_nxt;
      out_unsup_r <= res.unsup;
      out_fault_r <= res.fault;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.next_pc     = out_pc_r;
  assign out_chan.dest_value  = out_dest_r;
  assign out_chan.flag_value  = out_flag_r;
  assign out_chan.index_value = out_index_r;
  assign out_chan.unsupported = out_unsup_r;
  assign out_chan.stack_fault = out_fault_r;

endmodule
